/* design/mips1_pkg.sv */
package mips1_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_ADDRESS  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_SYSCALL  = 3'd4;
  localparam logic [2:0] ST_BREAK    = 3'd5;
  localparam logic [2:0] ST_ABORT    = 3'd6;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SETPC = 2'd3;

  localparam logic CFG_MEM_LIMIT = 1'b0;
  localparam logic CFG_LOW_BASE  = 1'b1;

  localparam logic [14:0] MEM_LIMIT_RST = 15'd16384;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pc_out;
    logic [31:0] rdata;
    logic [19:0] trap_code;
  } res_t;

  // range and alignment check of a byte address
  function automatic logic addr_ok(input logic [31:0] a, input logic [14:0] lo,
                                   input logic [31:0] lim, input logic [1:0] mask);
    addr_ok = (a >= 32'(lo)) && (a < lim) && ((a[1:0] & mask) == 2'b00);
  endfunction

endpackage

/* design/mips1_ram.sv */
module mips1_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mips1_div.sv */
module mips1_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sgn_i,
  input  logic [31:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, done_q, negq_q, negr_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q, dvs_q;
  logic [32:0] part, diff;

  // one quotient bit per cycle on magnitudes
  assign part = {rem_q[31:0], quo_q[31]};
  assign diff = part - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      negq_q <= sgn_i & (dvd_i[31] ^ dvs_i[31]);
      negr_q <= sgn_i & dvd_i[31];
      quo_q  <= (sgn_i & dvd_i[31]) ? -dvd_i : dvd_i;
      dvs_q  <= (sgn_i & dvs_i[31]) ? -dvs_i : dvs_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= part;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = negq_q ? -quo_q : quo_q;
  assign rem_o  = negr_q ? -rem_q[31:0] : rem_q[31:0];

endmodule

/* design/mips1_instruction_step.sv */
// mips i core driven one command per word.
// input channel: req_i is taken at a clock edge with start high and busy low.
//   cmd exec runs one instruction, write/read move one memory word, set pc
//   loads the pc and drops any pending delay slot.
// result channel: done_o is high for exactly one cycle with res_o; the
//   receiver cannot stall, res_o keeps the word only until the next result.
// config channel: cfg_valid_i/cfg_ready_o write mem_limit (index 0) or
//   low_base (index 1); ready is always high, write only while not busy.
// steps: host write, set pc and a fetch fault answer straight from idle, host
//   read passes the read state. an alu, branch or jump instruction steps through
//   fetch read, rs read and rt read of the register file memory, then execute.
//   loads and stores add the mem state for the data memory read, partial stores
//   write the merged word back in that state. mult adds the mul state, div waits
//   in the div state for the radix-2 divider unless the divisor is zero. one
//   item at a time; busy stays high until done.
// reset clears pc, delay slot, hi, lo, low_base and the register file (through
//   valid bits), sets mem_limit to 16384; main memory is empty until written.
module mips1_instruction_step #(
  parameter int MEM_WORDS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mips1_pkg::req_t req_i,
  output logic            done_o,
  output mips1_pkg::res_t res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [14:0]     cfg_data_i
);
  import mips1_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [5:0] OP_SPECIAL = 6'd0, OP_REGIMM = 6'd1, OP_J = 6'd2, OP_JAL = 6'd3;
  localparam logic [5:0] OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLEZ = 6'd6, OP_BGTZ = 6'd7;
  localparam logic [5:0] OP_ADDI = 6'd8, OP_ADDIU = 6'd9, OP_SLTI = 6'd10, OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI = 6'd12, OP_ORI = 6'd13, OP_XORI = 6'd14, OP_LUI = 6'd15;
  localparam logic [5:0] OP_LB = 6'd32, OP_LH = 6'd33, OP_LWL = 6'd34, OP_LW = 6'd35;
  localparam logic [5:0] OP_LBU = 6'd36, OP_LHU = 6'd37, OP_LWR = 6'd38;
  localparam logic [5:0] OP_SB = 6'd40, OP_SH = 6'd41, OP_SWL = 6'd42, OP_SW = 6'd43;
  localparam logic [5:0] OP_SWR = 6'd46;

  localparam logic [5:0] FN_SLL = 6'd0, FN_SRL = 6'd2, FN_SRA = 6'd3, FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6, FN_SRAV = 6'd7, FN_JR = 6'd8, FN_JALR = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12, FN_BREAK = 6'd13, FN_MFHI = 6'd16;
  localparam logic [5:0] FN_MTHI = 6'd17, FN_MFLO = 6'd18, FN_MTLO = 6'd19;
  localparam logic [5:0] FN_MULT = 6'd24, FN_MULTU = 6'd25, FN_DIV = 6'd26, FN_DIVU = 6'd27;
  localparam logic [5:0] FN_ADD = 6'd32, FN_ADDU = 6'd33, FN_SUB = 6'd34, FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND = 6'd36, FN_OR = 6'd37, FN_XOR = 6'd38, FN_NOR = 6'd39;
  localparam logic [5:0] FN_SLT = 6'd42, FN_SLTU = 6'd43;

  typedef enum logic [3:0] {
    S_IDLE, S_HRD, S_FETCH, S_RS, S_RT, S_EXEC, S_MEM, S_MUL, S_DIV
  } state_e;

  typedef enum logic [2:0] {K_ALU, K_HILO, K_MUL, K_DIV, K_MEM} kind_e;

  state_e      state_q;
  logic [31:0] pc_q, dly_q, hi_q, lo_q, pc_d, dly_d;
  logic [31:1] vld_q;
  logic [14:0] lim_cfg_q, low_q;
  logic        done_q, hrd_ok_q;
  res_t        res_q;
  logic [31:0] ir_q, a_q, b_q;
  logic [63:0] prod_q;

  logic        acc, in_slot, fetch_ok, host_in, commit, resp, exec_ok;
  logic [31:0] lim, fa, pc4, pc8;
  logic [11:0] host_idx;

  logic [5:0]  op, fn;
  logic [4:0]  rs_f, rt_f, rd_f, sa_f;
  logic [31:0] simm, ea, sum, dif, sumi;
  logic [1:0]  s;
  logic [2:0]  d_st;
  kind_e       d_kind;
  logic        d_wen, d_jump;
  logic [4:0]  d_dst;
  logic [31:0] d_val, d_tgt;
  logic [19:0] d_trap;

  logic [31:0] mem_rdata, gpr_rdata, ld_val, st_val;
  logic        mem_we, gpr_we, is_store;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0] mem_wdata, gpr_wdata;
  logic [4:0]  gpr_raddr;
  logic [4:0]  sh, shl3, sh_up;
  logic [5:0]  shp1, sh4m;

  logic        div_start, div_done;
  logic [31:0] div_quo, div_rem;

  assign cfg_ready_o = 1'b1;
  assign busy   = (state_q != S_IDLE);
  assign acc    = start && (state_q == S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign lim = (32'(lim_cfg_q) > 32'(MEM_WORDS * 4)) ? 32'(MEM_WORDS * 4)
                                                     : 32'(lim_cfg_q);
  assign in_slot  = (dly_q != 32'd0);
  assign fa       = in_slot ? dly_q : pc_q;
  assign fetch_ok = addr_ok(fa, low_q, lim, 2'b11);
  assign host_idx = req_i.addr[13:2];
  assign host_in  = (32'(host_idx) < 32'(MEM_WORDS));
  assign pc4 = pc_q + 32'd4;
  assign pc8 = pc_q + 32'd8;

  // instruction fields
  assign op   = ir_q[31:26];
  assign rs_f = ir_q[25:21];
  assign rt_f = ir_q[20:16];
  assign rd_f = ir_q[15:11];
  assign sa_f = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign ea   = a_q + simm;
  assign s    = ea[1:0];
  assign sum  = a_q + b_q;
  assign dif  = a_q - b_q;
  assign sumi = a_q + simm;

  always_comb begin
    d_st   = ST_OK;
    d_kind = K_ALU;
    d_wen  = 1'b0;
    d_dst  = rd_f;
    d_val  = '0;
    d_jump = 1'b0;
    d_tgt  = '0;
    d_trap = '0;
    unique case (op) inside
      OP_SPECIAL: begin
        unique case (fn) inside
          FN_SLL, FN_SRL, FN_SRA: begin
            if (rs_f != 5'd0) d_st = ST_INVALID;
            d_wen = 1'b1;
            d_val = (fn == FN_SLL) ? (b_q << sa_f) :
                    (fn == FN_SRL) ? (b_q >> sa_f) : 32'($signed(b_q) >>> sa_f);
          end
          FN_SLLV, FN_SRLV, FN_SRAV: begin
            if (sa_f != 5'd0) d_st = ST_INVALID;
            d_wen = 1'b1;
            d_val = (fn == FN_SLLV) ? (b_q << a_q[4:0]) :
                    (fn == FN_SRLV) ? (b_q >> a_q[4:0]) : 32'($signed(b_q) >>> a_q[4:0]);
          end
          FN_JR: begin
            if (in_slot || ir_q[20:6] != 15'd0) d_st = ST_INVALID;
            d_jump = 1'b1;
            d_tgt  = a_q;
          end
          FN_JALR: begin
            if (in_slot || rt_f != 5'd0) d_st = ST_INVALID;
            d_jump = 1'b1;
            d_tgt  = a_q;
            d_wen  = 1'b1;
            d_val  = pc8;
          end
          FN_SYSCALL: begin
            d_st   = ST_SYSCALL;
            d_trap = ir_q[25:6];
          end
          FN_BREAK: begin
            d_st   = ST_BREAK;
            d_trap = {10'd0, ir_q[25:16]};
          end
          FN_MFHI, FN_MFLO: begin
            if (rs_f != 5'd0 || rt_f != 5'd0 || sa_f != 5'd0) d_st = ST_INVALID;
            d_wen = 1'b1;
            d_val = (fn == FN_MFHI) ? hi_q : lo_q;
          end
          FN_MTHI, FN_MTLO: begin
            if (ir_q[20:6] != 15'd0) d_st = ST_INVALID;
            d_kind = K_HILO;
          end
          FN_MULT, FN_MULTU: begin
            if (ir_q[15:6] != 10'd0) d_st = ST_INVALID;
            d_kind = K_MUL;
          end
          FN_DIV, FN_DIVU: begin
            if (ir_q[15:6] != 10'd0) d_st = ST_INVALID;
            d_kind = K_DIV;
          end
          FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
          FN_SLT, FN_SLTU: begin
            if (sa_f != 5'd0) d_st = ST_INVALID;
            d_wen = 1'b1;
            unique case (fn) inside
              FN_ADD: begin
                d_val = sum;
                if (a_q[31] == b_q[31] && sum[31] != a_q[31]) d_st = ST_OVERFLOW;
              end
              FN_ADDU: d_val = sum;
              FN_SUB: begin
                d_val = dif;
                if (a_q[31] != b_q[31] && dif[31] != a_q[31]) d_st = ST_OVERFLOW;
              end
              FN_SUBU: d_val = dif;
              FN_AND:  d_val = a_q & b_q;
              FN_OR:   d_val = a_q | b_q;
              FN_XOR:  d_val = a_q ^ b_q;
              FN_NOR:  d_val = ~(a_q | b_q);
              FN_SLT:  d_val = {31'd0, $signed(a_q) < $signed(b_q)};
              default: d_val = {31'd0, a_q < b_q};
            endcase
          end
          default: d_st = ST_INVALID;
        endcase
      end
      OP_REGIMM: begin
        if (!(rt_f == 5'd0 || rt_f == 5'd1 || rt_f == 5'd16 || rt_f == 5'd17) || in_slot)
          d_st = ST_INVALID;
        d_dst  = 5'd31;
        d_wen  = rt_f[4];
        d_val  = pc8;
        d_jump = rt_f[0] ? !a_q[31] : a_q[31];
        d_tgt  = pc4 + {simm[29:0], 2'b00};
      end
      OP_J, OP_JAL: begin
        if (in_slot) d_st = ST_INVALID;
        d_dst  = 5'd31;
        d_wen  = (op == OP_JAL);
        d_val  = pc8;
        d_jump = 1'b1;
        d_tgt  = (pc4 & 32'hF800_0000) | {4'd0, ir_q[25:0], 2'b00};
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        if (in_slot || (op[1] && rt_f != 5'd0)) d_st = ST_INVALID;
        unique case (op) inside
          OP_BEQ:  d_jump = (a_q == b_q);
          OP_BNE:  d_jump = (a_q != b_q);
          OP_BLEZ: d_jump = (a_q == 32'd0) || a_q[31];
          default: d_jump = (a_q != 32'd0) && !a_q[31];
        endcase
        d_tgt = pc4 + {simm[29:0], 2'b00};
      end
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        d_dst = rt_f;
        d_wen = 1'b1;
        unique case (op) inside
          OP_ADDI: begin
            d_val = sumi;
            if (a_q[31] == simm[31] && sumi[31] != a_q[31]) d_st = ST_OVERFLOW;
          end
          OP_ADDIU: d_val = sumi;
          OP_SLTI:  d_val = {31'd0, $signed(a_q) < $signed(simm)};
          OP_SLTIU: d_val = {31'd0, a_q < simm};
          OP_ANDI:  d_val = a_q & {16'd0, ir_q[15:0]};
          OP_ORI:   d_val = a_q | {16'd0, ir_q[15:0]};
          OP_XORI:  d_val = a_q ^ {16'd0, ir_q[15:0]};
          default: begin
            if (rs_f != 5'd0) d_st = ST_INVALID;
            d_val = {ir_q[15:0], 16'd0};
          end
        endcase
      end
      OP_LB, OP_LBU, OP_SB, OP_LH, OP_LHU, OP_SH, OP_LW, OP_SW,
      OP_LWL, OP_LWR, OP_SWL, OP_SWR: begin
        d_kind = K_MEM;
        d_dst  = rt_f;
        d_wen  = !op[3];
        unique case (op) inside
          OP_LB, OP_LBU, OP_SB: if (!addr_ok(ea, low_q, lim, 2'b00)) d_st = ST_ADDRESS;
          OP_LH, OP_LHU, OP_SH: if (!addr_ok(ea, low_q, lim, 2'b01)) d_st = ST_ADDRESS;
          OP_LW, OP_SW:         if (!addr_ok(ea, low_q, lim, 2'b11)) d_st = ST_ADDRESS;
          default: if (!addr_ok({ea[31:2], 2'b00}, low_q, lim, 2'b11)) d_st = ST_ADDRESS;
        endcase
      end
      default: d_st = ST_INVALID;
    endcase
  end

  // load alignment and partial store merge
  assign is_store = op[3];
  assign sh    = {s, 3'b000};
  assign shl3  = {~s, 3'b000};
  assign shp1  = {s + 2'd1 == 2'd0 ? 1'b1 : 1'b0, s + 2'd1, 3'b000};
  assign sh4m  = 6'(6'd4 - 6'(s)) << 3;
  assign sh_up = shp1[4:0];

  always_comb begin
    ld_val = mem_rdata;
    st_val = b_q;
    case (op)
      OP_LB:  ld_val = {{24{mem_rdata[sh+7]}}, 8'(mem_rdata >> sh)};
      OP_LBU: ld_val = {24'd0, 8'(mem_rdata >> sh)};
      OP_LH:  ld_val = {{16{mem_rdata[sh+15]}}, 16'(mem_rdata >> sh)};
      OP_LHU: ld_val = {16'd0, 16'(mem_rdata >> sh)};
      OP_LWL: ld_val = (mem_rdata << shl3) |
                       ((s != 2'd3) ? (b_q & (32'hFFFF_FFFF >> sh_up)) : 32'd0);
      OP_LWR: ld_val = (mem_rdata >> sh) |
                       ((s != 2'd0) ? (b_q & (32'hFFFF_FFFF << sh4m)) : 32'd0);
      OP_SB:  st_val = (mem_rdata & ~(32'h0000_00FF << sh)) | ({24'd0, b_q[7:0]} << sh);
      OP_SH:  st_val = (mem_rdata & ~(32'h0000_FFFF << sh)) | ({16'd0, b_q[15:0]} << sh);
      OP_SWL: st_val = ((s != 2'd3) ? (mem_rdata & (32'hFFFF_FFFF << sh_up)) : 32'd0) |
                       (b_q >> shl3);
      OP_SWR: st_val = ((s != 2'd0) ? (mem_rdata & (32'hFFFF_FFFF >> sh4m)) : 32'd0) |
                       (b_q << sh);
      default: ;
    endcase
  end

  // commit and response
  assign exec_ok = (state_q == S_EXEC) && (d_st == ST_OK);
  assign commit  = (exec_ok && (d_kind == K_ALU || d_kind == K_HILO ||
                                (d_kind == K_DIV && b_q == 32'd0))) ||
                   (state_q == S_MEM) || (state_q == S_MUL) ||
                   (state_q == S_DIV && div_done);
  assign resp    = commit || (state_q == S_EXEC && d_st != ST_OK) || (state_q == S_HRD) ||
                   (acc && ((req_i.cmd != CMD_EXEC && req_i.cmd != CMD_READ) ||
                            (req_i.cmd == CMD_EXEC && !fetch_ok)));
  assign div_start = exec_ok && d_kind == K_DIV && b_q != 32'd0;

  always_comb begin
    pc_d  = pc_q;
    dly_d = dly_q;
    if (acc && req_i.cmd == CMD_SETPC) begin
      pc_d  = req_i.wdata;
      dly_d = '0;
    end else if (commit) begin
      if (in_slot) begin
        dly_d = '0;
      end else if (d_jump) begin
        dly_d = pc4;
        pc_d  = d_tgt;
      end else begin
        pc_d = pc4;
      end
    end
  end

  // memory ports
  assign mem_raddr = (state_q == S_EXEC) ? ea[AW+1:2] :
                     (req_i.cmd == CMD_READ) ? AW'(host_idx) : fa[AW+1:2];
  assign mem_we    = (acc && req_i.cmd == CMD_WRITE && host_in) ||
                     (state_q == S_MEM && is_store);
  assign mem_waddr = (state_q == S_MEM) ? ea[AW+1:2] : AW'(host_idx);
  assign mem_wdata = (state_q == S_MEM) ? st_val : req_i.wdata;

  assign gpr_raddr = (state_q == S_FETCH) ? mem_rdata[25:21] : rt_f;
  assign gpr_we    = commit && d_wen && d_dst != 5'd0;
  assign gpr_wdata = (state_q == S_MEM) ? ld_val : d_val;

  mips1_ram #(.W(32), .D(MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mips1_ram #(.W(32), .D(32)) u_gpr (
    .clk_i   (clk_i),
    .we_i    (gpr_we),
    .waddr_i (d_dst),
    .wdata_i (gpr_wdata),
    .raddr_i (gpr_raddr),
    .rdata_o (gpr_rdata)
  );

  mips1_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sgn_i   (!fn[0]),
    .dvd_i   (a_q),
    .dvs_i   (b_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      dly_q     <= '0;
      hi_q      <= '0;
      lo_q      <= '0;
      vld_q     <= '0;
      lim_cfg_q <= MEM_LIMIT_RST;
      low_q     <= '0;
      done_q    <= 1'b0;
      hrd_ok_q  <= 1'b0;
      res_q     <= '0;
    end else begin
      pc_q   <= pc_d;
      dly_q  <= dly_d;
      done_q <= resp;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MEM_LIMIT) lim_cfg_q <= cfg_data_i;
        else low_q <= cfg_data_i;
      end
      if (gpr_we) vld_q[d_dst] <= 1'b1;
      if (resp) begin
        res_q.status    <= (state_q == S_EXEC) ? d_st :
                           (state_q == S_IDLE && req_i.cmd == CMD_EXEC) ? ST_ADDRESS : ST_OK;
        res_q.pc_out    <= pc_d;
        res_q.rdata     <= (state_q == S_HRD && hrd_ok_q) ? mem_rdata : 32'd0;
        res_q.trap_code <= (state_q == S_EXEC) ? d_trap : 20'd0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            hrd_ok_q <= host_in;
            if (req_i.cmd == CMD_READ) state_q <= S_HRD;
            else if (req_i.cmd == CMD_EXEC && fetch_ok) state_q <= S_FETCH;
          end
        end
        S_HRD:   state_q <= S_IDLE;
        S_FETCH: state_q <= S_RS;
        S_RS:    state_q <= S_RT;
        S_RT:    state_q <= S_EXEC;
        S_EXEC: begin
          if (d_st != ST_OK || commit) begin
            state_q <= S_IDLE;
            if (commit && d_kind == K_HILO) begin
              if (fn == FN_MTHI) hi_q <= a_q;
              else lo_q <= a_q;
            end
            if (commit && d_kind == K_DIV) begin
              // divide by zero
              hi_q <= '1;
              lo_q <= '1;
            end
          end else if (d_kind == K_MUL) begin
            state_q <= S_MUL;
          end else if (d_kind == K_DIV) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_MEM;
          end
        end
        S_MEM: state_q <= S_IDLE;
        S_MUL: begin
          hi_q    <= prod_q[63:32];
          lo_q    <= prod_q[31:0];
          state_q <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            hi_q    <= div_rem;
            lo_q    <= div_quo;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // instruction and operand words
  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH) ir_q <= mem_rdata;
    if (state_q == S_RS) a_q <= (rs_f != 5'd0 && vld_q[rs_f]) ? gpr_rdata : 32'd0;
    if (state_q == S_RT) b_q <= (rt_f != 5'd0 && vld_q[rt_f]) ? gpr_rdata : 32'd0;
    if (state_q == S_EXEC) begin
      prod_q <= 64'($signed({!fn[0] & a_q[31], a_q}) * $signed({!fn[0] & b_q[31], b_q}));
    end
  end

endmodule

/* design/mips1_chk.sv */
module mips1_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input mips1_pkg::res_t res_o
);
  import mips1_pkg::*;

  // an accepted word is either answered or keeps the block busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted word neither answered nor busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.status != 3'd7 && res_o.status != ST_ABORT)
    else $error("status code out of range");

  a_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != ST_SYSCALL && res_o.status != ST_BREAK
      |-> res_o.trap_code == 20'd0)
    else $error("trap code without trap");

  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != ST_OK |-> res_o.rdata == 32'd0)
    else $error("read data on a faulting word");

endmodule

bind mips1_instruction_step mips1_chk u_chk (.*);

/* tb/sv/mips1_isa_pkg.sv */
`timescale 1ns / 100ps
package mips1_isa_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_LWR     = 6'd38;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SWL     = 6'd42;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_SWR     = 6'd46;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZAL  = 5'd16;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  localparam int unsigned MEM_WORDS = 4096;

endpackage

/* tb/sv/mips1_step_checker.sv */
`timescale 1ns / 100ps
module mips1_step_checker
  import mips1_pkg::*;
  import mips1_isa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  res_t        res_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output int          err_cnt_o,
  output int          pend_cnt_o
);

  logic [31:0] gpr [32];
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] pc, slot_pc, hi, lo;
  logic [14:0] mem_limit, low_base;
  res_t        expected_q[$];

  function automatic bit addr_good(logic [31:0] a, logic [1:0] mask);
    logic [31:0] lim;
    lim = (32'(mem_limit) > MEM_WORDS * 4) ? MEM_WORDS * 4 : 32'(mem_limit);
    return a >= 32'(low_base) && a < lim && (a[1:0] & mask) == 2'b00;
  endfunction

  function automatic bit sum_ovf(longint z);
    return z > 64'sd2147483647 || z < -64'sd2147483648;
  endfunction

  task automatic run_insn(output logic [2:0] st, output logic [19:0] tc);
    bit          in_slot, jmp, set_hi, set_lo, do_store;
    logic [31:0] fa, w, a, b, imm, simm, ea, wa, m, val, tgt, nhi, nlo, sval;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [1:0]  s;
    int          dst;
    longint      z;
    logic [63:0] p;
    st = ST_OK; tc = '0;
    in_slot = slot_pc != 0;
    fa = in_slot ? slot_pc : pc;
    dst = -1; val = '0; jmp = 0; set_hi = 0; set_lo = 0; do_store = 0;
    tgt = '0; nhi = '0; nlo = '0; sval = '0;
    if (!addr_good(fa, 2'b11)) begin
      st = ST_ADDRESS;
      return;
    end
    w = mem[fa[13:2]];
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6]; fn = w[5:0];
    a = gpr[rs]; b = gpr[rt];
    imm = {16'h0, w[15:0]}; simm = {{16{w[15]}}, w[15:0]};
    ea = a + simm; s = ea[1:0]; wa = {ea[31:2], 2'b00};
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL, FN_SRL, FN_SRA: begin
            if (rs != 0) begin st = ST_INVALID; return; end
            dst = rd;
            if (fn == FN_SLL) val = b << sa;
            else if (fn == FN_SRL) val = b >> sa;
            else val = $signed(b) >>> sa;
          end
          FN_SLLV, FN_SRLV, FN_SRAV: begin
            if (sa != 0) begin st = ST_INVALID; return; end
            dst = rd;
            if (fn == FN_SLLV) val = b << a[4:0];
            else if (fn == FN_SRLV) val = b >> a[4:0];
            else val = $signed(b) >>> a[4:0];
          end
          FN_JR: begin
            if (in_slot || w[20:6] != 0) begin st = ST_INVALID; return; end
            jmp = 1; tgt = a;
          end
          FN_JALR: begin
            if (in_slot || rt != 0) begin st = ST_INVALID; return; end
            jmp = 1; tgt = a; dst = rd; val = pc + 8;
          end
          FN_SYSCALL: begin
            tc = w[25:6]; st = ST_SYSCALL; return;
          end
          FN_BREAK: begin
            tc = {10'h0, w[25:16]}; st = ST_BREAK; return;
          end
          FN_MFHI, FN_MFLO: begin
            if (rs != 0 || rt != 0 || sa != 0) begin st = ST_INVALID; return; end
            dst = rd; val = (fn == FN_MFHI) ? hi : lo;
          end
          FN_MTHI, FN_MTLO: begin
            if (w[20:6] != 0) begin st = ST_INVALID; return; end
            if (fn == FN_MTHI) begin set_hi = 1; nhi = a; end
            else begin set_lo = 1; nlo = a; end
          end
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            if (w[15:6] != 0) begin st = ST_INVALID; return; end
            set_hi = 1; set_lo = 1;
            if (fn == FN_MULT) begin
              p = longint'($signed(a)) * longint'($signed(b));
              nhi = p[63:32]; nlo = p[31:0];
            end else if (fn == FN_MULTU) begin
              p = {32'h0, a} * {32'h0, b};
              nhi = p[63:32]; nlo = p[31:0];
            end else if (b == 0) begin
              nhi = '1; nlo = '1;
            end else if (fn == FN_DIV) begin
              if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                nlo = 32'h8000_0000; nhi = '0;
              end else begin
                nlo = $signed(a) / $signed(b);
                nhi = $signed(a) % $signed(b);
              end
            end else begin
              nlo = a / b; nhi = a % b;
            end
          end
          FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
          FN_SLT, FN_SLTU: begin
            if (sa != 0) begin st = ST_INVALID; return; end
            dst = rd;
            case (fn)
              FN_ADD: begin
                z = longint'($signed(a)) + longint'($signed(b));
                if (sum_ovf(z)) begin st = ST_OVERFLOW; return; end
                val = a + b;
              end
              FN_ADDU: val = a + b;
              FN_SUB: begin
                z = longint'($signed(a)) - longint'($signed(b));
                if (sum_ovf(z)) begin st = ST_OVERFLOW; return; end
                val = a - b;
              end
              FN_SUBU: val = a - b;
              FN_AND:  val = a & b;
              FN_OR:   val = a | b;
              FN_XOR:  val = a ^ b;
              FN_NOR:  val = ~(a | b);
              FN_SLT:  val = {31'h0, $signed(a) < $signed(b)};
              default: val = {31'h0, a < b};
            endcase
          end
          default: begin st = ST_INVALID; return; end
        endcase
      end
      OP_REGIMM: begin
        if (rt != RT_BLTZ && rt != RT_BGEZ && rt != RT_BLTZAL && rt != RT_BGEZAL) begin
          st = ST_INVALID; return;
        end
        if (in_slot) begin st = ST_INVALID; return; end
        // link variants write r31 taken or not
        if (rt[4]) begin dst = 31; val = pc + 8; end
        jmp = rt[0] ? !a[31] : a[31];
        tgt = pc + 4 + (simm << 2);
      end
      OP_J, OP_JAL: begin
        if (in_slot) begin st = ST_INVALID; return; end
        if (op == OP_JAL) begin dst = 31; val = pc + 8; end
        jmp = 1;
        tgt = ((pc + 4) & 32'hF800_0000) | {4'h0, w[25:0], 2'b00};
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        if (in_slot) begin st = ST_INVALID; return; end
        if ((op == OP_BLEZ || op == OP_BGTZ) && rt != 0) begin st = ST_INVALID; return; end
        if (op == OP_BEQ) jmp = a == b;
        else if (op == OP_BNE) jmp = a != b;
        else if (op == OP_BLEZ) jmp = a == 0 || a[31];
        else jmp = a != 0 && !a[31];
        tgt = pc + 4 + (simm << 2);
      end
      OP_ADDI: begin
        z = longint'($signed(a)) + longint'($signed(simm));
        if (sum_ovf(z)) begin st = ST_OVERFLOW; return; end
        dst = rt; val = a + simm;
      end
      OP_ADDIU: begin dst = rt; val = a + simm; end
      OP_SLTI:  begin dst = rt; val = {31'h0, $signed(a) < $signed(simm)}; end
      OP_SLTIU: begin dst = rt; val = {31'h0, a < simm}; end
      OP_ANDI:  begin dst = rt; val = a & imm; end
      OP_ORI:   begin dst = rt; val = a | imm; end
      OP_XORI:  begin dst = rt; val = a ^ imm; end
      OP_LUI: begin
        if (rs != 0) begin st = ST_INVALID; return; end
        dst = rt; val = imm << 16;
      end
      OP_LB, OP_LBU, OP_SB: begin
        if (!addr_good(ea, 2'b00)) begin st = ST_ADDRESS; return; end
        m = mem[ea[13:2]];
        if (op == OP_SB) begin
          do_store = 1;
          sval = (m & ~(32'hFF << (8 * s))) | ((b & 32'hFF) << (8 * s));
        end else begin
          dst = rt; val = (m >> (8 * s)) & 32'hFF;
          if (op == OP_LB) val = {{24{val[7]}}, val[7:0]};
        end
      end
      OP_LH, OP_LHU, OP_SH: begin
        if (!addr_good(ea, 2'b01)) begin st = ST_ADDRESS; return; end
        m = mem[ea[13:2]];
        if (op == OP_SH) begin
          do_store = 1;
          sval = (m & ~(32'hFFFF << (8 * s))) | ((b & 32'hFFFF) << (8 * s));
        end else begin
          dst = rt; val = (m >> (8 * s)) & 32'hFFFF;
          if (op == OP_LH) val = {{16{val[15]}}, val[15:0]};
        end
      end
      OP_LW, OP_SW: begin
        if (!addr_good(ea, 2'b11)) begin st = ST_ADDRESS; return; end
        if (op == OP_LW) begin dst = rt; val = mem[ea[13:2]]; end
        else begin do_store = 1; sval = b; end
      end
      OP_LWL, OP_LWR, OP_SWL, OP_SWR: begin
        // unaligned forms only check the word that holds the byte
        if (!addr_good(wa, 2'b11)) begin st = ST_ADDRESS; return; end
        m = mem[wa[13:2]];
        case (op)
          OP_LWL: begin
            dst = rt;
            val = (m << (8 * (3 - s))) | ((s != 3) ? b & (32'hFFFF_FFFF >> (8 * (s + 1))) : 0);
          end
          OP_LWR: begin
            dst = rt;
            val = (m >> (8 * s)) | ((s != 0) ? b & (32'hFFFF_FFFF << (8 * (4 - s))) : 0);
          end
          OP_SWL: begin
            do_store = 1;
            sval = ((s != 3) ? m & (32'hFFFF_FFFF << (8 * (s + 1))) : 0) | (b >> (8 * (3 - s)));
          end
          default: begin
            do_store = 1;
            sval = ((s != 0) ? m & (32'hFFFF_FFFF >> (8 * (4 - s))) : 0) | (b << (8 * s));
          end
        endcase
      end
      default: begin st = ST_INVALID; return; end
    endcase

    if (dst > 0) gpr[dst] = val;
    if (set_hi) hi = nhi;
    if (set_lo) lo = nlo;
    if (do_store) mem[ea[13:2]] = sval;
    if (in_slot) begin
      slot_pc = '0;
    end else if (jmp) begin
      slot_pc = pc + 4;
      pc = tgt;
    end else begin
      pc = pc + 4;
    end
  endtask

  task automatic predict_step(input req_t r, output res_t e);
    logic [2:0]  st;
    logic [19:0] tc;
    logic [31:0] rd_word;
    st = ST_OK; tc = '0; rd_word = '0;
    case (r.cmd)
      CMD_EXEC:  run_insn(st, tc);
      CMD_WRITE: mem[r.addr[13:2]] = r.wdata;
      CMD_READ:  rd_word = mem[r.addr[13:2]];
      default: begin
        pc = r.wdata;
        slot_pc = '0;
      end
    endcase
    e.status = st;
    e.pc_out = pc;
    e.rdata = rd_word;
    e.trap_code = tc;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
      pc = '0; slot_pc = '0; hi = '0; lo = '0;
      mem_limit = MEM_LIMIT_RST;
      low_base = '0;
      expected_q.delete();
      pend_cnt_o = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10)
            $display("unexpected result word: status %0d pc %h rdata %h trap %h",
                     res_i.status, res_i.pc_out, res_i.rdata, res_i.trap_code);
        end else begin
          e = expected_q.pop_front();
          if (res_i.status !== e.status || res_i.pc_out !== e.pc_out ||
              res_i.rdata !== e.rdata || res_i.trap_code !== e.trap_code) begin
            err_cnt_o++;
            if (err_cnt_o <= 10)
              $display("result differs: exp status %0d pc %h rdata %h trap %h, got %0d %h %h %h",
                       e.status, e.pc_out, e.rdata, e.trap_code,
                       res_i.status, res_i.pc_out, res_i.rdata, res_i.trap_code);
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_step(req_i, e);
        expected_q.push_back(e);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_MEM_LIMIT) mem_limit = cfg_data_i;
        else low_base = cfg_data_i;
      end
      pend_cnt_o = expected_q.size();
    end
  end

  initial err_cnt_o = 0;

endmodule

/* tb/sv/mips1_instruction_step_tb.sv */
`timescale 1ns / 100ps
module mips1_instruction_step_tb;
  import mips1_pkg::*;
  import mips1_isa_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done_o;
  res_t        res_o;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [14:0] cfg_data;
  int          err_cnt, pend_cnt;
  int          cycles = 0;
  int          n_items = 0, n_cfg = 0;
  bit          no_idle = 0;
  // byte window that holds written words, programs and host reads stay in it
  int          win_lo = 0, win_hi = 512;
  logic [31:0] dir_words[$];
  bit          dir_traps[$];

  always #4 clk_i = ~clk_i;

  mips1_instruction_step uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req),
    .done_o(done_o), .res_o(res_o), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  mips1_step_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .req_i(req),
    .done_i(done_o), .res_i(res_o), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .err_cnt_o(err_cnt),
    .pend_cnt_o(pend_cnt)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("mips1_instruction_step: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // mostly well-formed encodings, base registers r1..r7 kept for addresses
  function automatic logic [31:0] rand_insn();
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [5:0]  op, fn;
    rs = $urandom_range(0, 31); rt = $urandom_range(0, 31); rd = $urandom_range(0, 31);
    sa = $urandom_range(0, 31); imm = $urandom();
    case ($urandom_range(0, 11))
      0: begin
        case ($urandom_range(0, 9))
          0: fn = FN_ADD;  1: fn = FN_ADDU; 2: fn = FN_SUB; 3: fn = FN_SUBU;
          4: fn = FN_AND;  5: fn = FN_OR;   6: fn = FN_XOR; 7: fn = FN_NOR;
          8: fn = FN_SLT;  default: fn = FN_SLTU;
        endcase
        return rtype(rs, rt, rd, 5'd0, fn);
      end
      1: begin
        case ($urandom_range(0, 5))
          0: return rtype(5'd0, rt, rd, sa, FN_SLL);
          1: return rtype(5'd0, rt, rd, sa, FN_SRL);
          2: return rtype(5'd0, rt, rd, sa, FN_SRA);
          3: return rtype(rs, rt, rd, 5'd0, FN_SLLV);
          4: return rtype(rs, rt, rd, 5'd0, FN_SRLV);
          default: return rtype(rs, rt, rd, 5'd0, FN_SRAV);
        endcase
      end
      2: begin
        case ($urandom_range(0, 7))
          0: return rtype(rs, rt, 5'd0, 5'd0, FN_MULT);
          1: return rtype(rs, rt, 5'd0, 5'd0, FN_MULTU);
          2: return rtype(rs, rt, 5'd0, 5'd0, FN_DIV);
          3: return rtype(rs, rt, 5'd0, 5'd0, FN_DIVU);
          4: return rtype(5'd0, 5'd0, rd, 5'd0, FN_MFHI);
          5: return rtype(5'd0, 5'd0, rd, 5'd0, FN_MFLO);
          6: return rtype(rs, 5'd0, 5'd0, 5'd0, FN_MTHI);
          default: return rtype(rs, 5'd0, 5'd0, 5'd0, FN_MTLO);
        endcase
      end
      3: begin
        case ($urandom_range(0, 7))
          0: op = OP_ADDI; 1: op = OP_ADDIU; 2: op = OP_SLTI; 3: op = OP_SLTIU;
          4: op = OP_ANDI; 5: op = OP_ORI;   6: op = OP_XORI; default: op = OP_LUI;
        endcase
        return itype(op, (op == OP_LUI) ? 5'd0 : rs, rt, imm);
      end
      4, 5: return itype(OP_ORI, 5'd0, 5'($urandom_range(1, 7)),
                         16'($urandom_range(win_lo, win_hi - 1) & ~3));
      6, 7, 8: begin
        case ($urandom_range(0, 11))
          0: op = OP_LB;  1: op = OP_LH;  2: op = OP_LWL; 3: op = OP_LW;
          4: op = OP_LBU; 5: op = OP_LHU; 6: op = OP_LWR; 7: op = OP_SB;
          8: op = OP_SH;  9: op = OP_SWL; 10: op = OP_SW; default: op = OP_SWR;
        endcase
        return itype(op, 5'($urandom_range(1, 7)), rt, 16'($urandom_range(0, 127) - 64));
      end
      9: begin
        imm = 16'($urandom_range(0, 32) - 16);
        case ($urandom_range(0, 9))
          0: return {OP_J, 26'($urandom_range(win_lo / 4, win_hi / 4 - 1))};
          1: return {OP_JAL, 26'($urandom_range(win_lo / 4, win_hi / 4 - 1))};
          2: return itype(OP_BEQ, rs, rt, imm);
          3: return itype(OP_BNE, rs, rt, imm);
          4: return itype(OP_BLEZ, rs, 5'd0, imm);
          5: return itype(OP_BGTZ, rs, 5'd0, imm);
          6: begin
            case ($urandom_range(0, 3))
              0: rt = RT_BLTZ; 1: rt = RT_BGEZ; 2: rt = RT_BLTZAL; default: rt = RT_BGEZAL;
            endcase
            return itype(OP_REGIMM, rs, rt, imm);
          end
          7: return rtype(5'($urandom_range(1, 7)), 5'd0, 5'd0, 5'd0, FN_JR);
          default: return rtype(5'($urandom_range(1, 7)), 5'd0, rd, 5'd0, FN_JALR);
        endcase
      end
      10: begin
        if ($urandom_range(0, 1)) return {OP_SPECIAL, 20'($urandom()), FN_SYSCALL};
        return {OP_SPECIAL, 20'($urandom()), FN_BREAK};
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(input logic [1:0] c, input logic [13:0] ad, input logic [31:0] wd);
    int g;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= '{cmd: c, addr: ad, wdata: wd};
    do @(posedge clk_i); while (busy);
    n_items++;
    if (n_items % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [14:0] lim, input logic [14:0] base);
    drain();
    cfg_valid <= 1'b1; cfg_index <= CFG_MEM_LIMIT; cfg_data <= lim;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_LOW_BASE; cfg_data <= base;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int          k, len;
    logic [13:0] at;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) < 7) begin
        // short program: load it, point the pc at it, step through
        len = $urandom_range(3, 10);
        at = 14'(4 * $urandom_range(win_lo / 4, win_hi / 4 - len));
        for (int i = 0; i < len; i++) issue(CMD_WRITE, at + 14'(4 * i), rand_insn());
        issue(CMD_SETPC, 14'($urandom()), {18'h0, at});
        for (int i = 0; i < len + 2; i++) issue(CMD_EXEC, 14'($urandom()), $urandom());
        k += 2 * len + 3;
      end else begin
        case ($urandom_range(0, 3))
          0: issue(CMD_EXEC, 14'($urandom()), $urandom());
          1: issue(CMD_WRITE, 14'($urandom()), $urandom_range(0, 1) ? rand_insn() : $urandom());
          2: issue(CMD_READ, 14'(4 * $urandom_range(win_lo / 4, win_hi / 4 - 1)), $urandom());
          default: issue(CMD_SETPC, 14'($urandom()),
                         $urandom_range(0, 3) ?
                           {18'h0, 14'(4 * $urandom_range(win_lo / 4, win_hi / 4 - 1))} :
                           $urandom());
        endcase
        k++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MEM_LIMIT;
    cfg_data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_limits(15'd512, 15'd0);
    // fill a low and a top window so no fetch, load or host read sees an unwritten word
    for (int i = 0; i < 128; i++)
      issue(CMD_WRITE, 14'(i * 4), $urandom_range(0, 3) ? rand_insn() : $urandom());
    win_lo = 16256; win_hi = 16384;
    for (int i = MEM_WORDS - 32; i < MEM_WORDS; i++)
      issue(CMD_WRITE, 14'(i * 4), $urandom_range(0, 3) ? rand_insn() : $urandom());
    win_lo = 0; win_hi = 512;

    dir_words = '{
      itype(OP_ORI, 5'd0, 5'd1, 16'h0100),
      itype(OP_LUI, 5'd0, 5'd2, 16'h8000),
      itype(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF),
      rtype(5'd2, 5'd2, 5'd4, 5'd0, FN_ADD),
      rtype(5'd2, 5'd3, 5'd0, 5'd0, FN_DIV),
      rtype(5'd0, 5'd0, 5'd5, 5'd0, FN_MFLO),
      rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU),
      rtype(5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI),
      rtype(5'd2, 5'd3, 5'd0, 5'd0, FN_MULT),
      rtype(5'd3, 5'd3, 5'd0, 5'd0, FN_MULTU),
      itype(OP_SW, 5'd1, 5'd3, 16'h0000),
      itype(OP_SB, 5'd1, 5'd1, 16'h0003),
      itype(OP_LWL, 5'd1, 5'd7, 16'h0001),
      itype(OP_LWR, 5'd1, 5'd8, 16'h0002),
      itype(OP_LH, 5'd1, 5'd9, 16'h0001),
      rtype(5'd0, 5'd2, 5'd10, 5'd31, FN_SRA),
      {OP_SPECIAL, 20'hFFFFF, FN_SYSCALL},
      {OP_SPECIAL, 10'h3FF, 10'h0, FN_BREAK},
      itype(OP_REGIMM, 5'd3, RT_BGEZAL, 16'h0004),
      rtype(5'd1, 5'd0, 5'd1, 5'd0, FN_JALR),
      {OP_J, 26'h0}
    };
    // traps leave the pc in place, so the host moves past them
    dir_traps = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 0, 1};
    foreach (dir_words[i]) issue(CMD_WRITE, 14'(14'h0180 + 4 * i), dir_words[i]);
    issue(CMD_SETPC, 14'h0, 32'h0180);
    foreach (dir_words[i]) begin
      issue(CMD_EXEC, 14'h0, 32'h0);
      if (dir_traps[i]) issue(CMD_SETPC, 14'h0, 32'h0180 + 4 * (i + 1));
    end
    issue(CMD_WRITE, 14'h3FFF, 32'hFFFF_FFFF);
    issue(CMD_READ, 14'h3FFF, 32'h0);

    random_phase(90);
    set_limits(15'd384, 15'd128);
    win_lo = 128; win_hi = 384;
    random_phase(50);
    set_limits(15'd0, 15'h7FFF);
    win_lo = 0; win_hi = 512;
    random_phase(30);
    set_limits(15'd511, 15'd1);
    random_phase(60);
    // limit above the memory size, only the top window is reachable
    set_limits(15'h7FFF, 15'd16256);
    win_lo = 16256; win_hi = 16384;
    random_phase(60);

    drain();
    repeat (60) @(posedge clk_i);
    $display("ran %0d commands over %0d limit settings, two preloaded windows and program bursts",
             n_items, n_cfg);
    $display("%0d mismatches, %0d results still owed", err_cnt, pend_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("mips1_instruction_step: match");
    end else begin
      $display("mips1_instruction_step: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mips1_pkg.sv
design/mips1_ram.sv
design/mips1_div.sv
design/mips1_instruction_step.sv
design/mips1_chk.sv
tb/sv/mips1_isa_pkg.sv
tb/sv/mips1_step_checker.sv
tb/sv/mips1_instruction_step_tb.sv
